### rtl/rfs_pkg.sv
// ----------------------------------------------------------------------------
// rfs_pkg
// Shared types and codes for the timestamped ring FIFO with search.
// ----------------------------------------------------------------------------
package rfs_pkg;

    localparam int STAMP_W   = 32;
    localparam int PAYLOAD_W = 64;
    localparam int SLOT_W    = 8;

    localparam logic [1:0] ACT_PUSH = 2'd0;
    localparam logic [1:0] ACT_POP  = 2'd1;
    localparam logic [1:0] ACT_FIND = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    typedef struct packed {
        logic [1:0]           action;
        logic [STAMP_W-1:0]   stamp_in;
        logic [PAYLOAD_W-1:0] payload_in;
    } t_in_item;

    typedef struct packed {
        logic [1:0]           status;
        logic [STAMP_W-1:0]   stamp_out;
        logic [PAYLOAD_W-1:0] payload_out;
        logic [SLOT_W-1:0]    found_slot;
    } t_out_item;

endpackage

### rtl/rfs_ram.sv
// ----------------------------------------------------------------------------
// rfs_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module rfs_ram #(
    parameter int DEPTH = 256,
    parameter int WIDTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // hold read data until the next read
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/timestamped_ring_fifo_search_core.sv
// ----------------------------------------------------------------------------
// timestamped_ring_fifo_search_core
// Ring FIFO of timestamped records with binary search of stamps by slot.
// ----------------------------------------------------------------------------
// Replies: push, empty pop and unused actions are registered from the
//   accepting cycle; pop goes via the RAM read and S_POP, find via S_FIND.
// Throughput: one transaction in flight; the stamp RAM read port sets the
//   find rate at one probe per cycle.
// Reset: synchronous; pointers and counts clear, then a clearing pass zeroes
//   the stamp RAM while no input is accepted.
// ----------------------------------------------------------------------------
module timestamped_ring_fifo_search_core #(
    parameter int DEPTH        = 256,
    parameter int PAYLOAD_BITS = 64
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  rfs_pkg::t_in_item i_in,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output rfs_pkg::t_out_item o_out
);
    import rfs_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

    typedef enum logic [1:0] {S_CLEAR, S_IDLE, S_POP, S_FIND} t_state;

    t_state           r_state, n_state;
    logic [AW-1:0]    r_front, n_front;
    logic [AW-1:0]    r_rear, n_rear;
    logic [AW-1:0]    r_held, n_held;
    logic [AW-1:0]    r_wcnt, n_wcnt;
    logic [AW-1:0]    r_clr, n_clr;
    logic [AW:0]      r_lo, n_lo;
    logic [AW:0]      r_hi, n_hi;
    logic [AW-1:0]    r_mid, n_mid;
    logic [STAMP_W-1:0] r_key, n_key;
    logic             r_out_valid, n_out_valid;
    t_out_item        r_out, n_out;

    logic                    st_we, st_re, pl_we, pl_re;
    logic [AW-1:0]           st_waddr, st_raddr, pl_addr;
    logic [STAMP_W-1:0]      st_wdata, st_rdata;
    logic [PAYLOAD_BITS-1:0] pl_rdata;

    logic          out_free, accept;
    logic [AW-1:0] next_rear, next_front;
    logic [AW+1:0] sum;
    logic [AW:0]   f_lo, f_hi;
    logic          f_done;
    logic [AW-1:0] f_slot;
    logic [AW+SLOT_W-1:0]         slot_ext;
    logic [PAYLOAD_BITS+PAYLOAD_W-1:0] pl_ext;

    assign out_free   = !r_out_valid || i_out_ready;
    assign o_in_ready = (r_state == S_IDLE) && out_free;
    assign accept     = i_in_valid && o_in_ready;
    assign next_rear  = (r_rear == LAST) ? '0 : r_rear + 1'b1;
    assign next_front = (r_front == LAST) ? '0 : r_front + 1'b1;
    assign slot_ext   = {{SLOT_W{1'b0}}, f_slot};
    assign pl_ext     = {{PAYLOAD_W{1'b0}}, pl_rdata};

    rfs_ram #(.DEPTH(DEPTH), .WIDTH(STAMP_W)) u_stamp_ram (
        .i_clk   (i_clk),
        .i_we    (st_we),
        .i_waddr (st_waddr),
        .i_wdata (st_wdata),
        .i_re    (st_re),
        .i_raddr (st_raddr),
        .o_rdata (st_rdata)
    );

    rfs_ram #(.DEPTH(DEPTH), .WIDTH(PAYLOAD_BITS)) u_payload_ram (
        .i_clk   (i_clk),
        .i_we    (pl_we),
        .i_waddr (pl_addr),
        .i_wdata (i_in.payload_in[PAYLOAD_BITS-1:0]),
        .i_re    (pl_re),
        .i_raddr (pl_addr),
        .o_rdata (pl_rdata)
    );

    // one search probe: compare, narrow bounds, pick the next midpoint
    always_comb begin
        f_lo   = r_lo;
        f_hi   = r_hi;
        f_done = 1'b0;
        f_slot = '0;
        if (r_key == st_rdata) begin
            f_done = 1'b1;
            f_slot = r_mid;
        end else if (r_key < st_rdata) begin
            if (r_mid == '0) begin
                f_done = 1'b1;
            end else begin
                f_hi = {1'b0, r_mid} - 1'b1;
            end
        end else begin
            f_lo = {1'b0, r_mid} + 1'b1;
        end
        if (!f_done && (f_lo > f_hi)) begin
            f_done = 1'b1;
        end
        sum = {1'b0, f_lo} + {1'b0, f_hi};
    end

    always_comb begin
        n_state     = r_state;
        n_front     = r_front;
        n_rear      = r_rear;
        n_held      = r_held;
        n_wcnt      = r_wcnt;
        n_clr       = r_clr;
        n_lo        = r_lo;
        n_hi        = r_hi;
        n_mid       = r_mid;
        n_key       = r_key;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out       = r_out;
        st_we       = 1'b0;
        st_waddr    = next_rear;
        st_wdata    = i_in.stamp_in;
        st_re       = 1'b0;
        st_raddr    = next_front;
        pl_we       = 1'b0;
        pl_re       = 1'b0;
        pl_addr     = next_rear;

        case (r_state)
            S_CLEAR: begin
                st_we    = 1'b1;
                st_waddr = r_clr;
                st_wdata = '0;
                n_clr    = r_clr + 1'b1;
                if (r_clr == LAST) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    n_out       = '0;
                    n_out.status = ST_OK;
                    case (i_in.action)
                        ACT_PUSH: begin
                            n_out_valid = 1'b1;
                            if (next_rear == r_front || r_held == LAST) begin
                                n_out.status = ST_FULL;
                            end else begin
                                st_we  = 1'b1;
                                pl_we  = 1'b1;
                                n_rear = next_rear;
                                n_held = r_held + 1'b1;
                                n_wcnt = (r_wcnt == LAST) ? '0 : r_wcnt + 1'b1;
                            end
                        end
                        ACT_POP: begin
                            if (r_front == r_rear && r_held == '0) begin
                                n_out_valid  = 1'b1;
                                n_out.status = ST_EMPTY;
                            end else begin
                                st_re   = 1'b1;
                                pl_re   = 1'b1;
                                pl_addr = next_front;
                                n_front = next_front;
                                if (r_held != '0) begin
                                    n_held = r_held - 1'b1;
                                end
                                n_state = S_POP;
                            end
                        end
                        ACT_FIND: begin
                            st_re    = 1'b1;
                            st_raddr = r_wcnt >> 1;
                            n_lo     = '0;
                            n_hi     = {1'b0, r_wcnt};
                            n_mid    = r_wcnt >> 1;
                            n_key    = i_in.stamp_in;
                            n_state  = S_FIND;
                        end
                        default: begin
                            n_out_valid = 1'b1;
                        end
                    endcase
                end
            end
            S_POP: begin
                if (out_free) begin
                    n_out_valid       = 1'b1;
                    n_out             = '0;
                    n_out.status      = ST_OK;
                    n_out.stamp_out   = st_rdata;
                    n_out.payload_out = pl_ext[PAYLOAD_W-1:0];
                    n_state           = S_IDLE;
                end
            end
            S_FIND: begin
                if (f_done) begin
                    if (out_free) begin
                        n_out_valid      = 1'b1;
                        n_out            = '0;
                        n_out.status     = ST_OK;
                        n_out.found_slot = slot_ext[SLOT_W-1:0];
                        n_state          = S_IDLE;
                    end
                end else begin
                    st_re    = 1'b1;
                    st_raddr = sum[AW:1];
                    n_lo     = f_lo;
                    n_hi     = f_hi;
                    n_mid    = sum[AW:1];
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_front     <= '0;
            r_rear      <= '0;
            r_held      <= '0;
            r_wcnt      <= '0;
            r_clr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_front     <= n_front;
            r_rear      <= n_rear;
            r_held      <= n_held;
            r_wcnt      <= n_wcnt;
            r_clr       <= n_clr;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_lo  <= n_lo;
        r_hi  <= n_hi;
        r_mid <= n_mid;
        r_key <= n_key;
        r_out <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

### dv/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Testbench for timestamped_ring_fifo_search_core. A short list of directed
// transactions is followed by random push, pop and find traffic. The random
// traffic includes one fill to the full limit and one drain past empty. A
// testbench model of the ring works out each reply that the directed list
// does not give. Replies are compared field by field, in order. The sender
// works in bursts and the receiver stalls in changing patterns.
// ----------------------------------------------------------------------------
module tb;
    import rfs_pkg::*;

    localparam int DEPTH        = 256;
    localparam int PAYLOAD_BITS = 64;
    localparam int ITEM_TARGET  = 750;
    localparam int LIMIT_CYCLES = 200000;
    localparam int REPORT_MAX   = 10;

    localparam logic [1:0] ACT_NONE = 2'd3;
    localparam logic [PAYLOAD_W-1:0] PL_MASK = {PAYLOAD_W{1'b1}} >> (PAYLOAD_W - PAYLOAD_BITS);

    typedef struct {
        t_in_item  txn;
        bit        typed;
        t_out_item reply;
    } t_dir_row;

    logic      i_clk       = 1'b0;
    logic      i_rst_n     = 1'b0;
    logic      i_in_valid  = 1'b0;
    logic      o_in_ready;
    t_in_item  i_in        = '0;
    logic      o_out_valid;
    logic      i_out_ready = 1'b0;
    t_out_item o_out;

    int ring_front;
    int ring_rear;
    int ring_count;
    int ring_wcnt;
    logic [STAMP_W-1:0]   ring_stamps   [DEPTH];
    logic [PAYLOAD_W-1:0] ring_payloads [DEPTH];

    t_out_item queued_replies[$];
    t_dir_row  dir_rows[$];

    int cycles       = 0;
    int burst_left   = 0;
    int n_sent       = 0;
    int n_checked    = 0;
    int n_mismatch   = 0;
    int n_unexpected = 0;
    int n_full       = 0;
    int n_empty      = 0;
    int n_hit        = 0;
    int stall_mode   = 0;
    int stall_left   = 0;
    int rx_tick      = 0;
    logic [STAMP_W-1:0] stamp_next;

    timestamped_ring_fifo_search_core #(
        .DEPTH       (DEPTH),
        .PAYLOAD_BITS(PAYLOAD_BITS)
    ) u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in       (i_in),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out      (o_out)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT_CYCLES) begin
            $display("timeout after %0d cycles, %0d replies outstanding",
                     cycles, queued_replies.size());
            $display("simulation failed");
            $finish;
        end
    end

    function automatic t_out_item ring_fifo_step(input t_in_item txn);
        t_out_item r;
        int nxt;
        int lo;
        int hi;
        int mid;
        bit done;
        r = '0;
        case (txn.action)
            ACT_PUSH: begin
                nxt = (ring_rear + 1) % DEPTH;
                if (nxt == ring_front || ring_count == DEPTH - 1) begin
                    r.status = ST_FULL;
                    n_full++;
                end else begin
                    ring_rear = nxt;
                    ring_stamps[nxt] = txn.stamp_in;
                    ring_payloads[nxt] = txn.payload_in & PL_MASK;
                    ring_count++;
                    ring_wcnt = (ring_wcnt + 1) % DEPTH;
                end
            end
            ACT_POP: begin
                if (ring_front == ring_rear && ring_count == 0) begin
                    r.status = ST_EMPTY;
                    n_empty++;
                end else begin
                    ring_front = (ring_front + 1) % DEPTH;
                    r.stamp_out = ring_stamps[ring_front];
                    r.payload_out = ring_payloads[ring_front] & PL_MASK;
                    if (ring_count > 0) ring_count--;
                end
            end
            ACT_FIND: begin
                lo = 0;
                hi = ring_wcnt;
                done = 1'b0;
                while (!done && lo <= hi) begin
                    mid = (lo + hi) / 2;
                    if (txn.stamp_in < ring_stamps[mid]) begin
                        if (mid == 0) done = 1'b1;
                        else hi = mid - 1;
                    end else if (txn.stamp_in > ring_stamps[mid]) begin
                        lo = mid + 1;
                    end else begin
                        r.found_slot = mid[SLOT_W-1:0];
                        done = 1'b1;
                    end
                end
                if (r.found_slot != 0) n_hit++;
            end
            default: ;
        endcase
        return r;
    endfunction

    task automatic send_item(input t_in_item txn, input bit typed, input t_out_item reply);
        t_out_item model_reply;
        if (burst_left == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
            burst_left = $urandom_range(1, 16);
        end
        burst_left--;
        i_in_valid <= 1'b1;
        i_in <= txn;
        do @(posedge i_clk); while (!o_in_ready);
        model_reply = ring_fifo_step(txn);
        queued_replies.push_back(typed ? reply : model_reply);
        if (txn.action != ACT_NONE) n_sent++;
    endtask

    function automatic void add_row(input logic [1:0] act, input logic [STAMP_W-1:0] stamp,
                                    input logic [PAYLOAD_W-1:0] pl, input bit typed,
                                    input logic [1:0] st, input logic [STAMP_W-1:0] so,
                                    input logic [PAYLOAD_W-1:0] po,
                                    input logic [SLOT_W-1:0] fs);
        t_dir_row row;
        row.txn.action = act;
        row.txn.stamp_in = stamp;
        row.txn.payload_in = pl;
        row.typed = typed;
        row.reply.status = st;
        row.reply.stamp_out = so;
        row.reply.payload_out = po;
        row.reply.found_slot = fs;
        dir_rows.push_back(row);
    endfunction

    function automatic logic [STAMP_W-1:0] pick_key();
        int pick;
        logic [STAMP_W-1:0] k;
        pick = $urandom_range(0, 9);
        if (ring_wcnt > 0 && pick < 6) begin
            k = ring_stamps[$urandom_range(1, ring_wcnt)];
        end else if (ring_wcnt > 0 && pick < 8) begin
            k = ring_stamps[$urandom_range(1, ring_wcnt)];
            k = ($urandom_range(0, 1) != 0) ? k + 1 : k - 1;
        end else begin
            k = $urandom;
        end
        return k;
    endfunction

    task automatic send_random(input logic [1:0] act, input logic [STAMP_W-1:0] stamp);
        t_in_item txn;
        txn.action = act;
        txn.stamp_in = stamp;
        txn.payload_in = {$urandom, $urandom};
        send_item(txn, 1'b0, '0);
    endtask

    task automatic push_ascending();
        stamp_next = stamp_next + $urandom_range(1, 5000);
        send_random(ACT_PUSH, stamp_next);
    endtask

    task automatic mixed_step();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 42) push_ascending();
        else if (pick < 47) send_random(ACT_PUSH, $urandom);
        else if (pick < 75) send_random(ACT_POP, $urandom);
        else if (pick < 95) send_random(ACT_FIND, pick_key());
        else send_random(2'($urandom_range(0, 3)), $urandom);
    endtask

    always @(posedge i_clk) begin
        rx_tick <= rx_tick + 1;
        if (stall_left == 0) begin
            stall_mode <= $urandom_range(0, 2);
            stall_left <= $urandom_range(32, 200);
        end else begin
            stall_left <= stall_left - 1;
        end
        case (stall_mode)
            0: i_out_ready <= 1'b1;
            1: i_out_ready <= ($urandom_range(0, 3) != 0);
            default: i_out_ready <= (rx_tick % 4 == 3);
        endcase
    end

    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (queued_replies.size() == 0) begin
                n_unexpected++;
                if (n_unexpected + n_mismatch <= REPORT_MAX)
                    $display("unexpected reply: status=%0d stamp=%h payload=%h slot=%0d",
                             o_out.status, o_out.stamp_out, o_out.payload_out,
                             o_out.found_slot);
            end else begin
                want = queued_replies.pop_front();
                n_checked++;
                if (want.status !== o_out.status || want.stamp_out !== o_out.stamp_out ||
                    want.payload_out !== o_out.payload_out ||
                    want.found_slot !== o_out.found_slot) begin
                    n_mismatch++;
                    if (n_unexpected + n_mismatch <= REPORT_MAX) begin
                        $display("mismatch on reply %0d:", n_checked);
                        $display("  exp status=%0d stamp=%h payload=%h slot=%0d",
                                 want.status, want.stamp_out, want.payload_out,
                                 want.found_slot);
                        $display("  got status=%0d stamp=%h payload=%h slot=%0d",
                                 o_out.status, o_out.stamp_out, o_out.payload_out,
                                 o_out.found_slot);
                    end
                end
            end
        end
    end

    initial begin
        int errors;
        ring_front = 0;
        ring_rear = 0;
        ring_count = 0;
        ring_wcnt = 0;
        for (int i = 0; i < DEPTH; i++) begin
            ring_stamps[i] = '0;
            ring_payloads[i] = '0;
        end

        add_row(ACT_POP,  32'h0,         64'h0,                 1'b1, ST_EMPTY, '0, '0, '0);
        add_row(ACT_FIND, 32'h0,         64'h0,                 1'b1, ST_OK, '0, '0, '0);
        add_row(ACT_FIND, 32'hFFFF_FFFF, 64'h0,                 1'b1, ST_OK, '0, '0, '0);
        add_row(ACT_NONE, 32'hFFFF_FFFF, {PAYLOAD_W{1'b1}},     1'b1, ST_OK, '0, '0, '0);
        add_row(ACT_PUSH, 32'hFFFF_FFFF, {PAYLOAD_W{1'b1}},     1'b1, ST_OK, '0, '0, '0);
        add_row(ACT_FIND, 32'hFFFF_FFFF, 64'h0,                 1'b1, ST_OK, '0, '0, 8'd1);
        add_row(ACT_POP,  32'h0,         64'h0,                 1'b1, ST_OK, 32'hFFFF_FFFF,
                {PAYLOAD_W{1'b1}}, '0);
        add_row(ACT_POP,  32'h0,         64'h0,                 1'b1, ST_EMPTY, '0, '0, '0);
        add_row(ACT_PUSH, 32'h0,         64'h0,                 1'b1, ST_OK, '0, '0, '0);
        add_row(ACT_PUSH, 32'h0000_0010, 64'hA5A5_A5A5_A5A5_A5A5, 1'b1, ST_OK, '0, '0, '0);
        add_row(ACT_PUSH, 32'h8000_0000, 64'h5A5A_5A5A_5A5A_5A5A, 1'b1, ST_OK, '0, '0, '0);
        add_row(ACT_FIND, 32'h0000_0010, 64'h0,                 1'b0, ST_OK, '0, '0, '0);
        add_row(ACT_FIND, 32'h8000_0000, 64'h0,                 1'b0, ST_OK, '0, '0, '0);
        add_row(ACT_FIND, 32'h0,         64'h0,                 1'b0, ST_OK, '0, '0, '0);
        add_row(ACT_FIND, 32'h0000_0005, 64'h0,                 1'b0, ST_OK, '0, '0, '0);
        add_row(ACT_NONE, 32'h0,         64'h0,                 1'b1, ST_OK, '0, '0, '0);
        add_row(ACT_POP,  32'h0,         64'h0,                 1'b1, ST_OK, '0, '0, '0);
        add_row(ACT_POP,  32'h0,         64'h0,                 1'b0, ST_OK, '0, '0, '0);
        add_row(ACT_POP,  32'h0,         64'h0,                 1'b0, ST_OK, '0, '0, '0);
        add_row(ACT_POP,  32'h0,         64'h0,                 1'b1, ST_EMPTY, '0, '0, '0);
        add_row(ACT_FIND, 32'h7FFF_FFFF, 64'h0,                 1'b0, ST_OK, '0, '0, '0);

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[i]) send_item(dir_rows[i].txn, dir_rows[i].typed, dir_rows[i].reply);

        stamp_next = $urandom >> 1;
        while (n_sent < 150) mixed_step();

        while (ring_count < DEPTH - 1) begin
            if ($urandom_range(0, 9) == 0) send_random(ACT_FIND, pick_key());
            else push_ascending();
        end
        repeat (3) push_ascending();
        repeat (5) send_random(ACT_FIND, pick_key());
        while (ring_count > 0) begin
            if ($urandom_range(0, 9) == 0) send_random(ACT_FIND, pick_key());
            else send_random(ACT_POP, $urandom);
        end
        repeat (2) send_random(ACT_POP, $urandom);

        while (n_sent < ITEM_TARGET) mixed_step();

        i_in_valid <= 1'b0;
        while (queued_replies.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);

        errors = n_mismatch + n_unexpected + queued_replies.size();
        $display("%0d transactions sent, %0d replies checked, %0d mismatches, %0d unexpected",
                 n_sent, n_checked, n_mismatch, n_unexpected);
        $display("covered %0d full refusals, %0d empty pops, %0d find hits",
                 n_full, n_empty, n_hit);
        if (errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
